// ----- rtl/svt_pkg.sv -----
// Shared types and codes for the sorted value table.
`timescale 1ns / 1ps
`default_nettype none

package svt_pkg;

  localparam int DATA_W = 32;

  // Input kind codes.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Operation codes carried by the token that walks the cell chain.
  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
  } svt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
  } svt_out_t;

  // Operation token handed from cell to cell, one cell per cycle.
  // For an insert, hit means the value chain has landed in a free cell;
  // for a remove, hit means the match was found and cells now shift down.
  typedef struct packed {
    logic                     vld;
    logic [1:0]               op;
    logic                     hit;
    logic signed [DATA_W-1:0] value;
  } svt_tok_t;

endpackage

`default_nettype wire

// ----- rtl/svt_cell.sv -----
// One storage cell of the sorted chain: holds a value and passes the token on.
`timescale 1ns / 1ps
`default_nettype none

module svt_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire svt_pkg::svt_tok_t                tok_i,
  output svt_pkg::svt_tok_t                     tok_o,
  input  wire logic signed [svt_pkg::DATA_W-1:0] nb_val_i,
  input  wire logic                             nb_vld_i,
  output logic signed [svt_pkg::DATA_W-1:0]     val_o,
  output logic                                  vld_o
);

  logic signed [svt_pkg::DATA_W-1:0] val_r;
  logic signed [svt_pkg::DATA_W-1:0] val_nxt;
  logic                              vld_r;
  logic                              vld_nxt;
  svt_pkg::svt_tok_t                 tok_r;
  svt_pkg::svt_tok_t                 tok_nxt;

  // Apply the passing operation to this cell.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    tok_nxt = tok_i;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        svt_pkg::OP_INS: begin
          if (!tok_i.hit) begin
            if (!vld_r) begin
              // First free cell: the carried value lands here.
              val_nxt     = tok_i.value;
              vld_nxt     = 1'b1;
              tok_nxt.hit = 1'b1;
            end else if (!(val_r < tok_i.value)) begin
              // Carried value goes ahead of this one; push ours downstream.
              val_nxt       = tok_i.value;
              tok_nxt.value = val_r;
            end
          end
        end
        svt_pkg::OP_REM: begin
          // From the first match on, every cell takes its right neighbor.
          if (tok_i.hit || (vld_r && (val_r == tok_i.value))) begin
            val_nxt     = nb_val_i;
            vld_nxt     = nb_vld_i;
            tok_nxt.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cell value is payload only; the valid bit and the token are reset.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign val_o = val_r;
  assign vld_o = vld_r;

endmodule

`default_nettype wire

// ----- rtl/sorted_value_table.sv -----
// Top level of the sorted value table: launch, cell chain, count and result words.
`timescale 1ns / 1ps
`default_nettype none

// The table keeps up to CAPACITY signed 32-bit values in ascending order in a
// chain of cells. Each input word is an insert (placed ahead of equal copies)
// or a remove (first copy), and yields one result word with a status and the
// new count. An operation walks the chain one cell per cycle, and the next word
// is accepted only once the token of the previous one has left the last cell.
// One finished result can wait in the output stage while the next word is
// accepted; the result of that word then waits in a holding register, and
// input stalls until the output stage drains. No clearing pass is needed
// after reset.
module sorted_value_table #(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire svt_pkg::svt_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output svt_pkg::svt_out_t      out_data
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CEW = CW + 5;

  svt_pkg::svt_tok_t                 tok_link [0:CAPACITY];
  logic signed [svt_pkg::DATA_W-1:0] val_link [1:CAPACITY];
  logic                              vld_link [0:CAPACITY];

  svt_pkg::svt_tok_t head_r;
  svt_pkg::svt_tok_t head_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CEW-1:0]    count_ext;
  logic              busy_r;
  logic              out_valid_r;
  svt_pkg::svt_out_t out_data_r;
  logic              hold_vld_r;
  svt_pkg::svt_out_t hold_data_r;
  svt_pkg::svt_out_t res_word;
  svt_pkg::svt_tok_t tail;
  logic              in_fire;
  logic              out_take;
  logic              full;

  assign in_ready = !busy_r && !hold_vld_r;
  assign in_fire  = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign tail     = tok_link[CAPACITY];

  // Build the token for a newly accepted word; a refused insert walks as a no-op.
  always_comb begin
    head_nxt       = head_r;
    head_nxt.vld   = in_fire;
    head_nxt.hit   = 1'b0;
    head_nxt.value = in_data.value;
    if (in_data.kind == svt_pkg::KIND_REMOVE) begin
      head_nxt.op = svt_pkg::OP_REM;
    end else if (full) begin
      head_nxt.op = svt_pkg::OP_NOP;
    end else begin
      head_nxt.op = svt_pkg::OP_INS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign tok_link[0] = head_r;

  // Cell chain; the cell past the end reads as empty.
  assign val_link[CAPACITY] = '0;
  assign vld_link[CAPACITY] = 1'b0;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      svt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_i    (tok_link[gi]),
        .tok_o    (tok_link[gi+1]),
        .nb_val_i (val_link[gi+1]),
        .nb_vld_i (vld_link[gi+1]),
        .val_o    (),
        .vld_o    (vld_link[gi])
      );
    end else begin : g_body
      svt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_i    (tok_link[gi]),
        .tok_o    (tok_link[gi+1]),
        .nb_val_i (val_link[gi+1]),
        .nb_vld_i (vld_link[gi+1]),
        .val_o    (val_link[gi]),
        .vld_o    (vld_link[gi])
      );
    end
  end

  // New count and result word once the token leaves the last cell.
  always_comb begin
    count_nxt = count_r;
    res_word.status = svt_pkg::ST_DONE;
    unique case (tail.op)
      svt_pkg::OP_INS: begin
        count_nxt = count_r + CW'(1);
      end
      svt_pkg::OP_REM: begin
        if (tail.hit) begin
          count_nxt = count_r - CW'(1);
        end else begin
          res_word.status = svt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_word.status = svt_pkg::ST_FULL;
      end
    endcase
    count_ext            = CEW'(count_nxt);
    res_word.entry_count = count_ext[4:0];
  end

  // Count, busy flag, output stage and holding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hold_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end
      if (tail.vld) begin
        busy_r  <= 1'b0;
        count_r <= count_nxt;
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
          out_data_r  <= res_word;
        end else begin
          hold_vld_r  <= 1'b1;
          hold_data_r <= res_word;
        end
      end else if (out_take) begin
        if (hold_vld_r) begin
          out_data_r <= hold_data_r;
          hold_vld_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only one operation is ever in the chain.
  a_tail_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> busy_r)
    else $error("token left the chain with no operation in flight");

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The holding register is used only behind a waiting output word.
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> out_valid_r)
    else $error("holding register full while output stage empty");

  // At rest, the head cell is occupied exactly when the table is not empty.
  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (vld_link[0] == (count_r != '0)))
    else $error("head cell state disagrees with count");

  // An accepted word launches a token on the next cycle.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> head_r.vld)
    else $error("accepted word did not launch a token");

endmodule

`default_nettype wire
